[rtl/ess_pkg.sv]
`timescale 1ns / 1ps

package ess_pkg;

  // Sensor geometry and query limits.
  localparam int SENSOR_WIDTH  = 128;
  localparam int SENSOR_HEIGHT = 128;
  localparam int RESULT_CAP    = 64;
  localparam int PIX_COUNT     = SENSOR_WIDTH * SENSOR_HEIGHT;

  // Derived widths.
  localparam int COL_W   = $clog2(SENSOR_WIDTH);
  localparam int ROW_W   = $clog2(SENSOR_HEIGHT);
  localparam int ADDR_W  = $clog2(PIX_COUNT);
  localparam int OCC_W   = 15;
  localparam int N_W     = $clog2(RESULT_CAP + 1);
  localparam int POS_W   = 7;
  localparam int PAY_W   = 32;
  localparam int ENTRY_W = PAY_W + 1;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_RECT   = 2'd1;
  localparam logic [1:0] OP_RECENT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Result kinds.
  localparam logic [2:0] K_ADD_DONE   = 3'd0;
  localparam logic [2:0] K_PIXEL      = 3'd1;
  localparam logic [2:0] K_EMPTY      = 3'd2;
  localparam logic [2:0] K_CLEAR_DONE = 3'd3;
  localparam logic [2:0] K_REJECT     = 3'd4;

  // One result item as it travels from the sequencer to the output register.
  typedef struct packed {
    logic [2:0]       kind;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PAY_W-1:0] payload;
    logic             replaced;
    logic [OCC_W-1:0] occupied;
    logic             truncated;
    logic             last;
  } result_t;

endpackage

[rtl/event_surface_store_unit.sv]
`timescale 1ns / 1ps
// Add: pixel memory read, then write back; an out of range add is rejected without a memory access.
// Query: decode and setup, then one window pixel per cycle unless the output stalls, then a
// closing step unless the result cap ends the walk; one item at a time, as in_ready is high only when idle.
// Clear: one write per pixel across all PIX_COUNT (16384) entries, then the result item.
// After reset the same sweep over all entries empties the store while in_ready stays low.
module event_surface_store_unit
  import ess_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [11:0] in_col,
  input  logic signed [11:0] in_row,
  input  logic signed [11:0] in_col_end,
  input  logic signed [11:0] in_row_end,
  input  logic [6:0]         in_radius,
  input  logic [PAY_W-1:0]   in_payload,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [POS_W-1:0]   out_col,
  output logic [POS_W-1:0]   out_row,
  output logic [PAY_W-1:0]   out_payload,
  output logic               out_replaced,
  output logic [OCC_W-1:0]   out_occupied,
  output logic               out_truncated,
  output logic               out_last
);

  logic               rd_en, wr_en, load, out_free;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [ENTRY_W-1:0] rd_data, wr_data;
  result_t            load_res, out_res;

  // Pixel memory.
  ess_pixel_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Sequencer.
  ess_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_col_end   (in_col_end),
    .in_row_end   (in_row_end),
    .in_radius    (in_radius),
    .in_payload   (in_payload),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .load         (load),
    .load_res     (load_res),
    .out_free     (out_free)
  );

  // Output register.
  ess_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_res  (load_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .free      (out_free)
  );

  assign out_kind      = out_res.kind;
  assign out_col       = out_res.col;
  assign out_row       = out_res.row;
  assign out_payload   = out_res.payload;
  assign out_replaced  = out_res.replaced;
  assign out_occupied  = out_res.occupied;
  assign out_truncated = out_res.truncated;
  assign out_last      = out_res.last;

endmodule

[rtl/ess_pixel_mem.sv]
`timescale 1ns / 1ps

// Pixel store: one entry per pixel holding a valid mark over the payload.
module ess_pixel_mem
  import ess_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem_r [PIX_COUNT];
  logic [ENTRY_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/ess_out_reg.sv]
`timescale 1ns / 1ps

// Output register: holds one result item until the consumer takes it.
module ess_out_reg
  import ess_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res,
  output logic    free
);

  logic    valid_r;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload of the held item.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

[rtl/ess_ctrl.sv]
`timescale 1ns / 1ps

// Sequencer: decodes items, runs read-modify-write for adds, walks query
// windows one pixel per cycle unless the output stalls, and sweeps the store on clear and after reset.
module ess_ctrl
  import ess_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [11:0] in_col,
  input  logic signed [11:0] in_row,
  input  logic signed [11:0] in_col_end,
  input  logic signed [11:0] in_row_end,
  input  logic [6:0]         in_radius,
  input  logic [PAY_W-1:0]   in_payload,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [ENTRY_W-1:0] rd_data,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [ENTRY_W-1:0] wr_data,
  output logic               load,
  output result_t            load_res,
  input  logic               out_free
);

  typedef logic signed [12:0] coord_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_QSET  = 3'd3;
  localparam logic [2:0] S_QCHK  = 3'd4;
  localparam logic [2:0] S_QFIN  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam coord_t COL_MAX = coord_t'(SENSOR_WIDTH - 1);
  localparam coord_t ROW_MAX = coord_t'(SENSOR_HEIGHT - 1);

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(SENSOR_WIDTH) + ADDR_W'(c));
  endfunction

  function automatic coord_t clamp_lo(input coord_t v);
    return (v < 0) ? '0 : v;
  endfunction

  function automatic coord_t clamp_hi(input coord_t v, input coord_t lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic result_t mk_res(input logic [2:0] kind,
                                     input logic [POS_W-1:0] c,
                                     input logic [POS_W-1:0] r,
                                     input logic [PAY_W-1:0] pay,
                                     input logic rep,
                                     input logic [OCC_W-1:0] occ,
                                     input logic trunc,
                                     input logic lst);
    result_t res;
    res.kind      = kind;
    res.col       = c;
    res.row       = r;
    res.payload   = pay;
    res.replaced  = rep;
    res.occupied  = occ;
    res.truncated = trunc;
    res.last      = lst;
    return res;
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  sweep_r, sweep_nxt;
  logic               clr_emit_r, clr_emit_nxt;
  logic [OCC_W-1:0]   count_r, count_nxt;
  logic [COL_W-1:0]   rc_r, rc_nxt;
  logic [ROW_W-1:0]   rr_r, rr_nxt;
  logic               rv_r, rv_nxt;
  coord_t             cl_r, cl_nxt, ch_r, ch_nxt, rl_r, rl_nxt, rh_r, rh_nxt;
  logic               qempty_r, qempty_nxt;
  logic [COL_W-1:0]   c_r, c_nxt;
  logic [ROW_W-1:0]   r_r, r_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [COL_W-1:0]   pend_c_r, pend_c_nxt;
  logic [ROW_W-1:0]   pend_r_r, pend_r_nxt;
  logic [PAY_W-1:0]   pend_pay_r, pend_pay_nxt;
  logic [N_W-1:0]     n_r, n_nxt;
  result_t            stage_r, stage_nxt;

  // Decoded input coordinates, last added pixel and radius.
  coord_t             in_c, in_r, rc_s, rr_s, rad_s;
  logic               in_outside;
  logic               hit, at_end, advance;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  result_t            pend_res;

  assign in_c  = coord_t'(in_col);
  assign in_r  = coord_t'(in_row);
  assign rc_s  = coord_t'(rc_r);
  assign rr_s  = coord_t'(rr_r);
  assign rad_s = coord_t'(in_radius);
  assign in_outside = (in_c < 0) || (in_c > COL_MAX) || (in_r < 0) || (in_r > ROW_MAX);

  assign hit    = rd_data[PAY_W];
  assign at_end = (c_r == ch_r[COL_W-1:0]) && (r_r == rh_r[ROW_W-1:0]);
  assign pend_res = mk_res(K_PIXEL, POS_W'(pend_c_r), POS_W'(pend_r_r), pend_pay_r,
                           1'b0, count_r, 1'b0, 1'b0);

  // Next raster position inside the window.
  always_comb begin
    if (c_r == ch_r[COL_W-1:0]) begin
      col_next = cl_r[COL_W-1:0];
      row_next = r_r + ROW_W'(1);
    end else begin
      col_next = c_r + COL_W'(1);
      row_next = r_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Main sequencing logic.
  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    clr_emit_nxt = clr_emit_r;
    count_nxt    = count_r;
    rc_nxt       = rc_r;
    rr_nxt       = rr_r;
    rv_nxt       = rv_r;
    cl_nxt       = cl_r;
    ch_nxt       = ch_r;
    rl_nxt       = rl_r;
    rh_nxt       = rh_r;
    qempty_nxt   = qempty_r;
    c_nxt        = c_r;
    r_nxt        = r_r;
    pay_nxt      = pay_r;
    pend_v_nxt   = pend_v_r;
    pend_c_nxt   = pend_c_r;
    pend_r_nxt   = pend_r_r;
    pend_pay_nxt = pend_pay_r;
    n_nxt        = n_r;
    stage_nxt    = stage_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    load         = 1'b0;
    load_res     = pend_res;
    advance      = 1'b0;

    case (state_r)
      // Write every entry empty, one per cycle.
      S_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        sweep_nxt = sweep_r + ADDR_W'(1);
        if (sweep_r == ADDR_W'(PIX_COUNT - 1)) begin
          sweep_nxt = '0;
          if (clr_emit_r) begin
            stage_nxt = mk_res(K_CLEAR_DONE, '0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Decode a new item.
      S_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            OP_ADD: begin
              if (in_outside) begin
                stage_nxt = mk_res(K_REJECT, in_col[POS_W-1:0], in_row[POS_W-1:0], '0,
                                   1'b0, count_r, 1'b0, 1'b1);
                state_nxt = S_EMIT;
              end else begin
                c_nxt     = in_col[COL_W-1:0];
                r_nxt     = in_row[ROW_W-1:0];
                pay_nxt   = in_payload;
                rd_en     = 1'b1;
                rd_addr   = pix_addr(in_row[ROW_W-1:0], in_col[COL_W-1:0]);
                state_nxt = S_ADD;
              end
            end
            OP_RECT: begin
              cl_nxt     = clamp_lo(in_c);
              ch_nxt     = clamp_hi(coord_t'(in_col_end), COL_MAX);
              rl_nxt     = clamp_lo(in_r);
              rh_nxt     = clamp_hi(coord_t'(in_row_end), ROW_MAX);
              qempty_nxt = 1'b0;
              state_nxt  = S_QSET;
            end
            OP_RECENT: begin
              cl_nxt     = clamp_lo(rc_s - rad_s);
              ch_nxt     = clamp_hi(rc_s + rad_s, COL_MAX);
              rl_nxt     = clamp_lo(rr_s - rad_s);
              rh_nxt     = clamp_hi(rr_s + rad_s, ROW_MAX);
              qempty_nxt = !rv_r;
              state_nxt  = S_QSET;
            end
            default: begin
              count_nxt    = '0;
              rc_nxt       = '0;
              rr_nxt       = '0;
              rv_nxt       = 1'b0;
              clr_emit_nxt = 1'b1;
              sweep_nxt    = '0;
              state_nxt    = S_CLEAR;
            end
          endcase
        end
      end

      // Add: old entry is on the read port; write the new one back.
      S_ADD: begin
        if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = pix_addr(r_r, c_r);
          wr_data   = {1'b1, pay_r};
          count_nxt = hit ? count_r : count_r + OCC_W'(1);
          rc_nxt    = c_r;
          rr_nxt    = r_r;
          rv_nxt    = 1'b1;
          load      = 1'b1;
          load_res  = mk_res(K_ADD_DONE, POS_W'(c_r), POS_W'(r_r),
                             hit ? rd_data[PAY_W-1:0] : '0, hit, count_nxt, 1'b0, 1'b1);
          state_nxt = S_IDLE;
        end
      end

      // Query setup: reject empty windows, else read the first pixel.
      S_QSET: begin
        pend_v_nxt = 1'b0;
        n_nxt      = '0;
        if (qempty_r || (cl_r > ch_r) || (rl_r > rh_r)) begin
          stage_nxt = mk_res(K_EMPTY, '0, '0, '0, 1'b0, count_r, 1'b0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          c_nxt     = cl_r[COL_W-1:0];
          r_nxt     = rl_r[ROW_W-1:0];
          rd_en     = 1'b1;
          rd_addr   = pix_addr(rl_r[ROW_W-1:0], cl_r[COL_W-1:0]);
          state_nxt = S_QCHK;
        end
      end

      // Window walk: one found pixel is held back until the next one shows
      // whether it is the final result.
      S_QCHK: begin
        if (hit && (n_r == N_W'(RESULT_CAP))) begin
          if (out_free) begin
            load               = 1'b1;
            load_res.truncated = 1'b1;
            load_res.last      = 1'b1;
            state_nxt          = S_IDLE;
          end
        end else if (hit) begin
          if (!pend_v_r || out_free) begin
            load         = pend_v_r;
            pend_v_nxt   = 1'b1;
            pend_c_nxt   = c_r;
            pend_r_nxt   = r_r;
            pend_pay_nxt = rd_data[PAY_W-1:0];
            n_nxt        = n_r + N_W'(1);
            if (at_end) begin
              state_nxt = S_QFIN;
            end else begin
              advance = 1'b1;
            end
          end
        end else if (at_end) begin
          state_nxt = S_QFIN;
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          c_nxt   = col_next;
          r_nxt   = row_next;
          rd_en   = 1'b1;
          rd_addr = pix_addr(row_next, col_next);
        end
      end

      // End of window: release the held pixel, or report an empty window.
      S_QFIN: begin
        if (out_free) begin
          load = 1'b1;
          if (pend_v_r) begin
            load_res.last = 1'b1;
          end else begin
            load_res = mk_res(K_EMPTY, '0, '0, '0, 1'b0, count_r, 1'b0, 1'b1);
          end
          state_nxt = S_IDLE;
        end
      end

      // Single staged result.
      S_EMIT: begin
        if (out_free) begin
          load      = 1'b1;
          load_res  = stage_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      sweep_r    <= '0;
      clr_emit_r <= 1'b0;
      count_r    <= '0;
      rc_r       <= '0;
      rr_r       <= '0;
      rv_r       <= 1'b0;
      pend_v_r   <= 1'b0;
      n_r        <= '0;
      qempty_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      clr_emit_r <= clr_emit_nxt;
      count_r    <= count_nxt;
      rc_r       <= rc_nxt;
      rr_r       <= rr_nxt;
      rv_r       <= rv_nxt;
      pend_v_r   <= pend_v_nxt;
      n_r        <= n_nxt;
      qempty_r   <= qempty_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cl_r       <= cl_nxt;
    ch_r       <= ch_nxt;
    rl_r       <= rl_nxt;
    rh_r       <= rh_nxt;
    c_r        <= c_nxt;
    r_r        <= r_nxt;
    pay_r      <= pay_nxt;
    pend_c_r   <= pend_c_nxt;
    pend_r_r   <= pend_r_nxt;
    pend_pay_r <= pend_pay_nxt;
    stage_r    <= stage_nxt;
  end

endmodule
